### design/hzc_pkg.sv
package hzc_pkg;

  localparam int COORD_W     = 48;
  localparam int DEC_W       = 45;
  localparam int DIGIT_W     = 4;
  localparam int ZD_W        = 3;
  localparam int AP_W        = 2;
  localparam int RES_W       = 5;
  localparam int RADIX_W     = 3;
  localparam int REM_W       = 3;
  localparam int NIB_W       = 4;
  localparam int STEPS       = COORD_W / NIB_W;
  localparam int STEP_W      = $clog2(STEPS);
  localparam int MAX_RES_DEF = 16;
  localparam int CFG_DW      = 32;
  localparam int PADDR_W     = 3;

  localparam logic [AP_W-1:0] AP4 = 2'd0;
  localparam logic [AP_W-1:0] AP3 = 2'd1;
  localparam logic [AP_W-1:0] AP7 = 2'd2;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  localparam logic REG_APERTURE   = 1'b0;
  localparam logic REG_RESOLUTION = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic signed [COORD_W-1:0] coord_i;
    logic signed [COORD_W-1:0] coord_j;
    logic [DIGIT_W-1:0]        digit;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic [ZD_W-1:0]  z_digit;
    logic             last_digit;
    logic             is_decode;
    logic [DEC_W-1:0] dec_i;
    logic [DEC_W-1:0] dec_j;
    logic             bad_digit;
  } out_item_t;

  typedef struct packed {
    logic ld;
    logic run;
    logic wrap;
  } div_ctl_t;

  typedef struct packed {
    logic step;
    logic fix;
    logic clear;
  } dec_ctl_t;

  function automatic logic [RADIX_W-1:0] radix_of(input logic [AP_W-1:0] ap);
    case (ap)
      AP3:     return RADIX_W'(3);
      AP7:     return RADIX_W'(7);
      default: return RADIX_W'(2);
    endcase
  endfunction

endpackage

### design/hzc_stream_if.sv
interface hzc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/hzc_ram.sv
module hzc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/hzc_div.sv
module hzc_div (
  input  logic                          clk,
  input  hzc_pkg::div_ctl_t             ctl,
  input  logic [hzc_pkg::RADIX_W-1:0]   radix,
  input  logic [hzc_pkg::COORD_W-1:0]   value,
  output logic [hzc_pkg::REM_W-1:0]     rem
);
  import hzc_pkg::*;

  logic [COORD_W-1:0] a_r, a_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [NIB_W-1:0]   q;
  logic [REM_W:0]     t;
  logic [REM_W-1:0]   part;

  // long division, one nibble of the dividend per cycle while run is set, quotient shifts in at the bottom
  always_comb begin
    part = rem_r;
    q    = '0;
    t    = '0;
    for (int b = 0; b < NIB_W; b++) begin
      t = {part, a_r[COORD_W-1-b]};
      if (t >= {1'b0, radix}) begin
        q[NIB_W-1-b] = 1'b1;
        part         = REM_W'(t - {1'b0, radix});
      end else begin
        part = t[REM_W-1:0];
      end
    end
    rem_nxt = part;
    a_nxt   = {a_r[COORD_W-NIB_W-1:0], q};
  end

  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      a_r   <= value;
      rem_r <= '0;
    end else if (ctl.run) begin
      a_r   <= a_nxt;
      rem_r <= ctl.wrap ? '0 : rem_nxt;
    end
  end

  assign rem = rem_nxt;
endmodule

### design/hzc_dec.sv
module hzc_dec #(
  parameter int MAX_RES = hzc_pkg::MAX_RES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hzc_pkg::dec_ctl_t           ctl,
  input  logic [hzc_pkg::DIGIT_W-1:0] digit,
  input  logic [hzc_pkg::AP_W-1:0]    ap,
  input  logic [hzc_pkg::RES_W-1:0]   res_c,
  output logic [hzc_pkg::DEC_W-1:0]   acc_i,
  output logic [hzc_pkg::DEC_W-1:0]   acc_j,
  output logic                        err
);
  import hzc_pkg::*;

  localparam int CNT_W = $clog2(2 * MAX_RES + 1);

  logic [DEC_W-1:0]   acc_i_r, acc_i_nxt;
  logic [DEC_W-1:0]   acc_j_r, acc_j_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIGIT_W-1:0] prev_r, prev_nxt;
  logic               err_r, err_nxt;
  logic [RADIX_W-1:0] radix;
  logic               binary;

  function automatic logic [DEC_W-1:0] mul_rad(input logic [DEC_W-1:0] acc,
                                               input logic [AP_W-1:0] a);
    case (a)
      AP3:     return (acc << 1) + acc;
      AP7:     return (acc << 3) - acc;
      default: return acc << 1;
    endcase
  endfunction

  // missing j digit from the last i digit: d mod 3 through 0,2,1
  function automatic logic [1:0] jmap_of(input logic [DIGIT_W-1:0] d);
    if (d inside {4'd1, 4'd4, 4'd7, 4'd10, 4'd13}) begin
      return 2'd2;
    end else if (d inside {4'd2, 4'd5, 4'd8, 4'd11, 4'd14}) begin
      return 2'd1;
    end
    return 2'd0;
  endfunction

  assign radix  = radix_of(ap);
  assign binary = (radix == RADIX_W'(2));

  always_comb begin
    acc_i_nxt = acc_i_r;
    acc_j_nxt = acc_j_r;
    cnt_nxt   = cnt_r;
    prev_nxt  = prev_r;
    err_nxt   = err_r;
    if (ctl.clear) begin
      acc_i_nxt = '0;
      acc_j_nxt = '0;
      cnt_nxt   = '0;
      prev_nxt  = '0;
      err_nxt   = 1'b0;
    end else if (ctl.step) begin
      prev_nxt = digit;
      if (cnt_r >= CNT_W'(2 * MAX_RES)) begin
        err_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (binary) begin
          acc_i_nxt = mul_rad(acc_i_r, ap) + DEC_W'(digit >> 1);
          acc_j_nxt = mul_rad(acc_j_r, ap) + DEC_W'(digit[0]);
        end else begin
          if (digit >= DIGIT_W'(radix)) begin
            err_nxt = 1'b1;
          end
          if (!cnt_r[0]) begin
            acc_i_nxt = mul_rad(acc_i_r, ap) + DEC_W'(digit);
          end else begin
            acc_j_nxt = mul_rad(acc_j_r, ap) + DEC_W'(digit);
          end
        end
      end
    end else if (ctl.fix) begin
      if (ap == AP3 && res_c[0] && cnt_r[0] && !err_r) begin
        acc_j_nxt = mul_rad(acc_j_r, AP3) + DEC_W'(jmap_of(prev_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_i_r <= '0;
      acc_j_r <= '0;
      cnt_r   <= '0;
      prev_r  <= '0;
      err_r   <= 1'b0;
    end else begin
      acc_i_r <= acc_i_nxt;
      acc_j_r <= acc_j_nxt;
      cnt_r   <= cnt_nxt;
      prev_r  <= prev_nxt;
      err_r   <= err_nxt;
    end
  end

  assign acc_i = acc_i_r;
  assign acc_j = acc_j_r;
  assign err   = err_r;
endmodule

### design/hex_zorder_digit_codec.sv
// encode: the nibble-serial divider lanes make one digit per coordinate per pass over the dividend,
// then digits are read from the digit ram and emitted one at a time, waiting for a free output slot
// decode: one digit item per cycle while idle; the last digit passes the fix and output states
// a new item is taken only when the sequencer is idle; results wait in an output register
// sync active-low reset clears config, sequencer, decode state, out valid; not ram, lanes, out data
module hex_zorder_digit_codec #(
  parameter int MAX_RES = hzc_pkg::MAX_RES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  hzc_stream_if.sink                  in_ch,
  hzc_stream_if.source                out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hzc_pkg::PADDR_W-1:0] paddr,
  input  logic [hzc_pkg::CFG_DW-1:0]  pwdata,
  output logic [hzc_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import hzc_pkg::*;

  localparam int AW    = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int N_W   = $clog2(MAX_RES + 1);
  localparam int CNT_W = $clog2(2 * MAX_RES + 1);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_DIV     = 6'b000010,
    ST_EMIT_RD = 6'b000100,
    ST_EMIT_WR = 6'b001000,
    ST_DEC_FIX = 6'b010000,
    ST_DEC_OUT = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [AP_W-1:0]    ap_r;
  logic [RES_W-1:0]   res_r;
  logic [RES_W-1:0]   res_c;
  logic [RES_W:0]     res_p1;
  logic [N_W-1:0]     n_r, n_nxt, n_acc, n_m1;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt, cnt_acc;
  logic [AW-1:0]      m_r, m_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [CNT_W-1:0]   p_r, p_nxt, p_half;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;
  logic               slot_free;
  logic               in_fire;
  logic               cfg_wr;
  logic               binary;
  logic [RADIX_W-1:0] radix;
  logic [COORD_W-1:0] abs_i, abs_j;
  div_ctl_t           div_ctl;
  dec_ctl_t           dec_ctl;
  logic [REM_W-1:0]   rem_i, rem_j;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [N_W-1:0]     waddr_full;
  logic [2*REM_W-1:0] ram_rdata;
  logic [REM_W-1:0]   di, dj;
  logic [DEC_W-1:0]   acc_i, acc_j;
  logic               dec_err;

  function automatic logic [COORD_W-1:0] abs_of(input logic [COORD_W-1:0] x);
    return x[COORD_W-1] ? (~x + COORD_W'(1)) : x;
  endfunction

  // configuration port
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[PADDR_W-1])
      REG_APERTURE:   prdata = CFG_DW'(ap_r);
      REG_RESOLUTION: prdata = CFG_DW'(res_r);
      default:        prdata = '0;
    endcase
  end

  assign res_c  = (res_r > RES_W'(MAX_RES)) ? RES_W'(MAX_RES) : res_r;
  assign res_p1 = (RES_W + 1)'(res_c) + (RES_W + 1)'(1);
  assign radix  = radix_of(ap_r);
  assign binary = (radix == RADIX_W'(2));

  always_comb begin
    if (ap_r == AP3) begin
      n_acc = N_W'(res_p1 >> 1);
    end else begin
      n_acc = N_W'(res_c);
    end
    if (binary) begin
      cnt_acc = CNT_W'(n_acc);
    end else begin
      cnt_acc = CNT_W'({n_acc, 1'b0}) - CNT_W'(ap_r == AP3 && res_c[0]);
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  assign abs_i = abs_of(in_ch.data.coord_i);
  assign abs_j = abs_of(in_ch.data.coord_j);

  // digit addressing: lanes produce least significant digit first, written from the top
  assign n_m1       = n_r - N_W'(1);
  assign waddr_full = n_m1 - N_W'(m_r);
  assign ram_waddr  = waddr_full[AW-1:0];
  assign p_half     = p_r >> 1;
  assign ram_raddr  = binary ? p_r[AW-1:0] : p_half[AW-1:0];
  assign di         = ram_rdata[2*REM_W-1:REM_W];
  assign dj         = ram_rdata[REM_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    m_nxt         = m_r;
    step_nxt      = step_r;
    p_nxt         = p_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_item_nxt  = out_item_r;
    div_ctl       = '0;
    dec_ctl       = '0;
    ram_we        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.data.mode == MODE_DEC) begin
            dec_ctl.step = 1'b1;
            if (in_ch.data.last) begin
              state_nxt = ST_DEC_FIX;
            end
          end else begin
            div_ctl.ld = 1'b1;
            n_nxt      = n_acc;
            cnt_nxt    = cnt_acc;
            m_nxt      = '0;
            step_nxt   = '0;
            p_nxt      = '0;
            if (cnt_acc != '0) begin
              state_nxt = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        div_ctl.run  = 1'b1;
        div_ctl.wrap = (step_r == STEP_W'(STEPS - 1));
        if (div_ctl.wrap) begin
          ram_we   = 1'b1;
          step_nxt = '0;
          if (m_r == n_m1[AW-1:0]) begin
            state_nxt = ST_EMIT_RD;
          end else begin
            m_nxt = m_r + AW'(1);
          end
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt            = '0;
          out_item_nxt.z_digit    = binary ? {1'b0, di[0], dj[0]} : (p_r[0] ? dj : di);
          out_item_nxt.last_digit = (p_r == cnt_r - CNT_W'(1));
          if (p_r == cnt_r - CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            p_nxt     = p_r + CNT_W'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      ST_DEC_FIX: begin
        dec_ctl.fix = 1'b1;
        state_nxt   = ST_DEC_OUT;
      end
      ST_DEC_OUT: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt           = '0;
          out_item_nxt.is_decode = 1'b1;
          out_item_nxt.bad_digit = dec_err;
          out_item_nxt.dec_i     = dec_err ? '0 : acc_i;
          out_item_nxt.dec_j     = dec_err ? '0 : acc_j;
          dec_ctl.clear          = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ap_r        <= AP4;
      res_r       <= '0;
      n_r         <= '0;
      cnt_r       <= '0;
      m_r         <= '0;
      step_r      <= '0;
      p_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      cnt_r       <= cnt_nxt;
      m_r         <= m_nxt;
      step_r      <= step_nxt;
      p_r         <= p_nxt;
      if (cfg_wr) begin
        if (paddr[PADDR_W-1] == REG_RESOLUTION) begin
          res_r <= pwdata[RES_W-1:0];
        end else begin
          ap_r <= pwdata[AP_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  hzc_div u_div_i (
    .clk   (clk),
    .ctl   (div_ctl),
    .radix (radix),
    .value (abs_i),
    .rem   (rem_i)
  );

  hzc_div u_div_j (
    .clk   (clk),
    .ctl   (div_ctl),
    .radix (radix),
    .value (abs_j),
    .rem   (rem_j)
  );

  hzc_ram #(
    .WIDTH (2 * REM_W),
    .DEPTH (MAX_RES)
  ) u_digit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({rem_i, rem_j}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hzc_dec #(
    .MAX_RES (MAX_RES)
  ) u_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (dec_ctl),
    .digit (in_ch.data.digit),
    .ap    (ap_r),
    .res_c (res_c),
    .acc_i (acc_i),
    .acc_j (acc_j),
    .err   (dec_err)
  );

  a_div_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> N_W'(m_r) < n_r)
    else $error("digit index past digit count");

  a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT_WR |-> p_r < cnt_r)
    else $error("emit position past digit count");

  a_last_enc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.last_digit |-> !out_item_r.is_decode)
    else $error("last mark on a decode result");

  a_dec_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.data.mode == MODE_DEC && in_ch.data.last |=> state_r == ST_DEC_FIX)
    else $error("last decode digit did not start the finish step");

  a_fix_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DEC_FIX |=> state_r == ST_DEC_OUT)
    else $error("finish step not followed by decode result");
endmodule
